/* rtl/bso_pkg.sv */
package bso_pkg;

    // wave_mode codes
    localparam logic [1:0] MODE_Q88  = 2'd0;
    localparam logic [1:0] MODE_AUTO = 2'd1;
    localparam logic [1:0] MODE_8BIT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_TEMPO      = 2'd0;
    localparam logic [1:0] REG_WAVE_MODE  = 2'd1;
    localparam logic [1:0] REG_RANGE_LOW  = 2'd2;
    localparam logic [1:0] REG_RANGE_HIGH = 2'd3;

    localparam logic [15:0] TEMPO_RST = 16'd15360;
    localparam logic [15:0] HIGH_RST  = 16'hFFFF;
    localparam logic [8:0]  PHASE_MUL = 9'd280;
    localparam logic [15:0] SINE_MID  = 16'h8000;
    localparam logic [7:0]  SINE8_MID = 8'h80;

    typedef logic [2:0] t_sec16;
    typedef logic [1:0] t_sec8;

    function automatic logic [14:0] sin16_base(input t_sec16 sec);
        logic [14:0] v;
        unique case (sec)
            3'd0: v = 15'd0;
            3'd1: v = 15'd6393;
            3'd2: v = 15'd12539;
            3'd3: v = 15'd18204;
            3'd4: v = 15'd23170;
            3'd5: v = 15'd27245;
            3'd6: v = 15'd30273;
            3'd7: v = 15'd32137;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] sin16_slope(input t_sec16 sec);
        logic [5:0] v;
        unique case (sec)
            3'd0: v = 6'd49;
            3'd1: v = 6'd48;
            3'd2: v = 6'd44;
            3'd3: v = 6'd38;
            3'd4: v = 6'd31;
            3'd5: v = 6'd23;
            3'd6: v = 6'd14;
            3'd7: v = 6'd4;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

    function automatic logic [6:0] sin8_base(input t_sec8 sec);
        logic [6:0] v;
        unique case (sec)
            2'd0: v = 7'd0;
            2'd1: v = 7'd49;
            2'd2: v = 7'd90;
            2'd3: v = 7'd117;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] sin8_slope(input t_sec8 sec);
        logic [5:0] v;
        unique case (sec)
            2'd0: v = 6'd49;
            2'd1: v = 6'd41;
            2'd2: v = 6'd27;
            2'd3: v = 6'd10;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/beat_sine_oscillator_top.sv */
// Beat sine oscillator.
// Slave channel: one word per timestamp, tdata = time_ms (32 bits).
// Master channel: one word per timestamp, tdata = wave_value [15:0],
// beat_phase [31:16]. Results leave in input order.
// Config port: i_cfg_we / i_cfg_index / i_cfg_data, register index 0 tempo,
// 1 wave_mode, 2 range_low, 3 range_high; write only while the pipe is empty.
// Five register stages: tempo multiply, phase multiply, piecewise sine,
// range multiply, offset add into the output register. o_m_axis_tvalid rises once
// the word is in the output register; throughput is one word per cycle while
// the receiver does not stall.
// Each stage holds its word while the next stage is full and held, so a stalled
// receiver fills the pipe before o_s_axis_tready drops; nothing is lost
// or repeated. Bubbles close up under stall.
// Reset (synchronous, active low) empties the pipe and loads tempo 15360,
// mode 0, range 0..65535.
module beat_sine_oscillator_top
    import bso_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] time_ms
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] wave_value, [31:16] beat_phase
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_tempo;
    logic [1:0]  r_mode;
    logic [15:0] r_low;
    logic [15:0] r_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo <= TEMPO_RST;
            r_mode  <= MODE_Q88;
            r_low   <= 16'd0;
            r_high  <= HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TEMPO:      r_tempo <= i_cfg_data;
                REG_WAVE_MODE:  r_mode  <= i_cfg_data[1:0];
                REG_RANGE_LOW:  r_low   <= i_cfg_data;
                REG_RANGE_HIGH: r_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits and per-stage advance
    logic [5:1] r_v;
    logic [5:1] ce;

    assign ce[5] = !r_v[5] || i_m_axis_tready;
    assign ce[4] = !r_v[4] || ce[5];
    assign ce[3] = !r_v[3] || ce[4];
    assign ce[2] = !r_v[2] || ce[3];
    assign ce[1] = !r_v[1] || ce[2];
    assign o_s_axis_tready = ce[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ce[1]) r_v[1] <= i_s_axis_tvalid;
            if (ce[2]) r_v[2] <= r_v[1];
            if (ce[3]) r_v[3] <= r_v[2];
            if (ce[4]) r_v[4] <= r_v[3];
            if (ce[5]) r_v[5] <= r_v[4];
        end
    end

    // eight-bit mode flag travels with each word
    logic [5:1] r_m8;
    logic       mode8;
    assign mode8 = (r_mode >= MODE_8BIT);

    // stage 1: time * tempo
    logic [15:0] bpm;
    logic [47:0] prod1;
    logic [31:0] r_p1;

    assign bpm   = (r_mode != MODE_Q88 && r_tempo[15:8] == 8'd0) ?
                   {r_tempo[7:0], 8'd0} : r_tempo;
    assign prod1 = i_s_axis_tdata * bpm;

    // stage 2: * 280, keep bits 31:16
    logic [40:0] prod2;
    logic [15:0] r_ph2;
    assign prod2 = r_p1 * PHASE_MUL;

    // stage 3: piecewise sine
    logic [10:0] off16;
    t_sec16      sec16;
    logic [12:0] lin16;
    logic [15:0] y16;
    logic [15:0] s16;
    logic [7:0]  th8;
    logic [5:0]  off8;
    logic [4:0]  sub8;
    t_sec8       sec8;
    logic [10:0] lin8;
    logic [7:0]  y8;
    logic [7:0]  s8;
    logic [15:0] r_s3;
    logic [15:0] r_ph3;

    always_comb begin
        off16 = r_ph2[14] ? ~r_ph2[13:3] : r_ph2[13:3];
        sec16 = off16[10:8];
        lin16 = sin16_slope(sec16) * off16[7:1];
        y16   = {1'b0, sin16_base(sec16)} + {3'd0, lin16};
        s16   = r_ph2[15] ? (SINE_MID - y16) : (SINE_MID + y16);

        th8   = r_ph2[15:8];
        off8  = th8[6] ? ~th8[5:0] : th8[5:0];
        sub8  = {1'b0, off8[3:0]} + {4'd0, th8[6]};
        sec8  = off8[5:4];
        lin8  = sin8_slope(sec8) * sub8;
        y8    = {1'b0, sin8_base(sec8)} + {1'b0, lin8[10:4]};
        s8    = th8[7] ? (SINE8_MID - y8) : (SINE8_MID + y8);
    end

    // stage 4: sine * (1 + width)
    logic [15:0] width16;
    logic [16:0] span;
    logic [32:0] prod4;
    logic [15:0] r_sc4;
    logic [15:0] r_ph4;

    assign width16 = r_high - r_low;
    assign span    = r_m8[3] ? {8'd0, {1'b0, width16[7:0]} + 9'd1}
                             : {1'b0, width16} + 17'd1;
    assign prod4   = r_s3 * span;

    // stage 5: add lowest value
    logic [15:0] sum16;
    logic [7:0]  sum8;
    logic [15:0] r_wave5;
    logic [15:0] r_ph5;

    assign sum16 = r_low + r_sc4;
    assign sum8  = r_low[7:0] + r_sc4[7:0];

    always_ff @(posedge i_clk) begin
        if (ce[1]) begin
            r_p1    <= prod1[31:0];
            r_m8[1] <= mode8;
        end
        if (ce[2]) begin
            r_ph2   <= prod2[31:16];
            r_m8[2] <= r_m8[1];
        end
        if (ce[3]) begin
            r_s3    <= r_m8[2] ? {8'd0, s8} : s16;
            r_ph3   <= r_m8[2] ? {8'd0, r_ph2[15:8]} : r_ph2;
            r_m8[3] <= r_m8[2];
        end
        if (ce[4]) begin
            r_sc4   <= r_m8[3] ? {8'd0, prod4[15:8]} : prod4[31:16];
            r_ph4   <= r_ph3;
            r_m8[4] <= r_m8[3];
        end
        if (ce[5]) begin
            r_wave5 <= r_m8[4] ? {8'd0, sum8} : sum16;
            r_ph5   <= r_ph4;
            r_m8[5] <= r_m8[4];
        end
    end

    assign o_m_axis_tvalid = r_v[5];
    assign o_m_axis_tdata  = {r_ph5, r_wave5};

    // input stalls only when every stage holds a word
    a_full_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_v == 5'b11111))
        else $error("input stalled with a bubble in the pipe");

    // eight-bit words carry zero upper bytes
    a_m8_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[5] && r_m8[5]) |-> (r_wave5[15:8] == 8'd0 && r_ph5[15:8] == 8'd0))
        else $error("upper byte set on eight-bit word");

    // sixteen-bit sine never reaches the rails
    a_sine_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[3] && !r_m8[3]) |-> (r_s3 >= 16'd123 && r_s3 <= 16'd65413))
        else $error("sine out of span");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import bso_pkg::*;

    // wave_mode 3 is not a named mode; the block treats it as eight-bit
    localparam logic [1:0]  MODE_8BIT_ALT = 2'd3;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned PIPE_CYCLES   = 8;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned SEG_ITEMS     = 48;

    // piecewise sine knots, section 0 in the low slice
    localparam logic [127:0] SIN16_BASES  = {16'd32137, 16'd30273, 16'd27245, 16'd23170,
                                             16'd18204, 16'd12539, 16'd6393, 16'd0};
    localparam logic [63:0]  SIN16_SLOPES = {8'd4, 8'd14, 8'd23, 8'd31,
                                             8'd38, 8'd44, 8'd48, 8'd49};
    localparam logic [31:0]  SIN8_BASES   = {8'd117, 8'd90, 8'd49, 8'd0};
    localparam logic [31:0]  SIN8_SLOPES  = {8'd10, 8'd27, 8'd41, 8'd49};

    typedef struct packed {
        logic [15:0] phase;
        logic [15:0] wave;
    } osc_word_t;

    class wave_scoreboard;
        logic [15:0] tempo;
        logic [1:0]  mode;
        logic [15:0] low;
        logic [15:0] high;
        osc_word_t   expected_q[$];
        int unsigned errors;

        function new();
            tempo  = TEMPO_RST;
            mode   = MODE_Q88;
            low    = 16'd0;
            high   = HIGH_RST;
            errors = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [15:0] data);
            case (idx)
                REG_TEMPO:      tempo = data;
                REG_WAVE_MODE:  mode  = data[1:0];
                REG_RANGE_LOW:  low   = data;
                REG_RANGE_HIGH: high  = data;
                default: ;
            endcase
        endfunction

        function osc_word_t predict_wave(input logic [31:0] ms);
            logic [31:0] bpm, prod, off, sec, sub, y, s, w, v;
            logic [15:0] theta;
            logic [7:0]  th8;
            osc_word_t   res;
            bpm = {16'd0, tempo};
            if (mode != MODE_Q88 && bpm < 32'd256) bpm = bpm << 8;
            prod  = ms * bpm;
            prod  = prod * PHASE_MUL;
            theta = prod[31:16];
            if (mode[1]) begin
                // eight-bit path, four sections, mirrored on the falling quarter
                th8 = theta[15:8];
                off = {24'd0, th8};
                if (th8[6]) off = 32'd255 - off;
                off = off & 32'h3F;
                sub = off & 32'h0F;
                if (th8[6]) sub = sub + 32'd1;
                sec = off >> 4;
                y = SIN8_BASES[sec*8 +: 8] + ((SIN8_SLOPES[sec*8 +: 8] * sub) >> 4);
                s = th8[7] ? ((32'd128 - y) & 32'hFF) : ((32'd128 + y) & 32'hFF);
                w = (high - low) & 32'hFF;
                v = (low + ((s * (w + 32'd1)) >> 8)) & 32'hFF;
                res.phase = {8'd0, th8};
            end else begin
                off = {18'd0, theta[13:0]} >> 3;
                if (theta[14]) off = 32'd2047 - off;
                sec = off >> 8;
                y = SIN16_BASES[sec*16 +: 16]
                    + SIN16_SLOPES[sec*8 +: 8] * ((off & 32'hFF) >> 1);
                s = theta[15] ? ((32'd32768 - y) & 32'hFFFF) : ((32'd32768 + y) & 32'hFFFF);
                w = (high - low) & 32'hFFFF;
                v = (low + ((s * (w + 32'd1)) >> 16)) & 32'hFFFF;
                res.phase = theta;
            end
            res.wave = v[15:0];
            return res;
        endfunction

        function void note_time(input logic [31:0] ms);
            expected_q.push_back(predict_wave(ms));
        endfunction

        function void flag(input string what, input logic [31:0] want, input logic [31:0] got);
            errors++;
            if (errors <= REPORT_MAX)
                $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
        endfunction

        function void check_word(input logic [31:0] tdata);
            osc_word_t got, want;
            got = tdata;
            if (expected_q.size() == 0) begin
                flag("unexpected word", 32'd0, tdata);
                return;
            end
            want = expected_q.pop_front();
            if (got.wave !== want.wave)
                flag("wave_value", {16'd0, want.wave}, {16'd0, got.wave});
            if (got.phase !== want.phase)
                flag("beat_phase", {16'd0, want.phase}, {16'd0, got.phase});
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit passed();
            if (expected_q.size() != 0) begin
                $display("%0d words never arrived", expected_q.size());
                errors++;
            end
            return errors == 0;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    int unsigned    send_idle_pct;
    int unsigned    stall_pct;
    int unsigned    cycle_count = 0;
    wave_scoreboard sb = new();

    beat_sine_oscillator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** beat_sine_oscillator_top: FAILED **");
            $finish;
        end
    end

    // receiver: check accepted words, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) sb.check_word(o_m_axis_tdata);
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_word(input logic [31:0] ms);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ms;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_time(ms);
    endtask

    // always idles, even when no word is pending
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(input logic [15:0] tempo_v, input logic [15:0] mode_v,
                             input logic [15:0] low_v, input logic [15:0] high_v);
        drain_results();
        repeat (PIPE_CYCLES) @(posedge i_clk);
        put_reg(REG_TEMPO, tempo_v);
        put_reg(REG_WAVE_MODE, mode_v);
        put_reg(REG_RANGE_LOW, low_v);
        put_reg(REG_RANGE_HIGH, high_v);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_time();
        case ($urandom_range(3))
            0:       return $urandom_range(65535);
            1:       return 32'hFFFF_FFFF - $urandom_range(65535);
            default: return $urandom();
        endcase
    endfunction

    task automatic new_setting();
        logic [15:0] t, junk, lo, hi;
        logic [1:0]  m;
        case ($urandom_range(7))
            0:       t = 16'h0000;
            1:       t = 16'hFFFF;
            2:       t = 16'($urandom_range(1, 255));
            3:       t = 16'd255;
            4:       t = 16'd256;
            default: t = 16'($urandom_range(65535));
        endcase
        case ($urandom_range(3))
            0:       m = MODE_Q88;
            1:       m = MODE_AUTO;
            2:       m = MODE_8BIT;
            default: m = MODE_8BIT_ALT;
        endcase
        junk = 16'($urandom());
        lo   = 16'($urandom());
        hi   = 16'($urandom());
        case ($urandom_range(5))
            0: begin lo = 16'h0000; hi = 16'hFFFF; end
            1: hi = lo;
            2: begin lo = 16'hFFFF; hi = 16'h0000; end
            3: hi = lo + 16'($urandom_range(300));
            default: ;
        endcase
        configure(t, {junk[15:2], m}, lo, hi);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 32'd0;
        i_m_axis_tready <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= REG_TEMPO;
        i_cfg_data      <= 16'd0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings first, then corner settings
        send_word(32'd0);
        send_word(32'd1);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0000);
        send_word($urandom());
        configure(16'd255, {14'h3FFF, MODE_AUTO}, 16'h0000, 16'hFFFF);
        send_word(32'h7FFF_FFFF);
        send_word(32'hFFFF_FFFF);
        send_word($urandom());
        configure(16'hFFFF, {14'd0, MODE_8BIT}, 16'd10, 16'd200);
        send_word(32'hFFFF_FFFF);
        send_word($urandom());
        send_word($urandom());
        // zero tempo pins the phase, high below low wraps the width
        configure(16'd0, {14'd0, MODE_8BIT_ALT}, 16'hF0F0, 16'h0F0F);
        send_word($urandom());
        send_word(32'hFFFF_FFFF);
        configure(16'd1, {14'd0, MODE_Q88}, 16'hFFFF, 16'h0000);
        send_word(32'hFFFF_FFFF);
        send_word($urandom());
        send_word($urandom());
        configure(16'd256, {14'd0, MODE_AUTO}, 16'd1234, 16'd1234);
        send_word($urandom());
        send_word($urandom());
        configure(16'd100, {14'd0, MODE_8BIT}, 16'h00FF, 16'h0000);
        send_word($urandom());
        send_word($urandom());
        send_word(32'h0000_FFFF);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 75; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 75; end
                default: begin send_idle_pct = 6; stall_pct = 6; end
            endcase
            for (int seg = 0; seg < 9; seg++) begin
                new_setting();
                for (int i = 0; i < SEG_ITEMS; i++) begin
                    if ($urandom_range(39) == 0) drain_results();
                    send_word(rand_time());
                end
            end
        end

        drain_results();
        repeat (PIPE_CYCLES) @(posedge i_clk);
        if (sb.passed())
            $display("** beat_sine_oscillator_top: PASSED **");
        else
            $display("** beat_sine_oscillator_top: FAILED **");
        $finish;
    end

endmodule
